// File: src/sfpc_pkg.sv
`timescale 1ns / 1ps

package sfpc_pkg;

	// Output sample encodings, as written to the sample_encoding register
	typedef enum logic [1:0] {
		ENC_FLOAT32 = 2'd0,
		ENC_PCM16   = 2'd1,
		ENC_PCM24   = 2'd2,
		ENC_PCM32   = 2'd3
	} enc_t;

	// Configuration register indexes
	localparam logic [1:0] REG_SAMPLE_ENCODING = 2'd0;
	localparam logic [1:0] REG_CHANNEL_COUNT   = 2'd1;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// Frame buffer between the conversion pipeline and the word sequencer
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	// PCM full-scale factors
	localparam logic [30:0] K_PCM16 = 31'd32767;
	localparam logic [30:0] K_PCM24 = 31'd8388607;
	localparam logic [30:0] K_PCM32 = 31'd2147483647;

	localparam logic [31:0] FP_ONE = 32'h3F80_0000;
	localparam logic [31:0] FP_INF = 32'h7F80_0000;
	localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

endpackage

// File: src/sfpc_fadd.sv
`timescale 1ns / 1ps

module sfpc_fadd import sfpc_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);

	// align
	logic        a_big;
	logic [31:0] big, sml;
	logic [7:0]  eb, es, ebe, ese, d2;
	logic [23:0] mbig, msml;
	logic [26:0] mext, al2;

	logic [26:0] ma_s2, mb_s2;
	logic [7:0]  e_s2;
	logic        sub_s2, sign_s2, nan_s2, inf_s2;

	always_comb begin
		a_big = a[30:0] >= b[30:0];
		big = a_big ? a : b;
		sml = a_big ? b : a;
		eb = big[30:23];
		es = sml[30:23];
		ebe = (eb == 8'd0) ? 8'd1 : eb;
		ese = (es == 8'd0) ? 8'd1 : es;
		mbig = {eb != 8'd0, big[22:0]};
		msml = {es != 8'd0, sml[22:0]};
		d2 = ebe - ese;
		mext = {msml, 3'b000};
		if (d2 >= 8'd27) begin
			al2 = {26'd0, |msml};
		end else begin
			al2 = (mext >> d2) | {26'd0, |(mext & ((27'd1 << d2) - 27'd1))};
		end
	end

	always_ff @(posedge clk) begin
		ma_s2 <= {mbig, 3'b000};
		mb_s2 <= al2;
		e_s2 <= ebe;
		sub_s2 <= big[31] ^ sml[31];
		sign_s2 <= big[31];
		nan_s2 <= (eb == 8'hFF && big[22:0] != 23'd0) || (es == 8'hFF && sml[22:0] != 23'd0)
			|| (eb == 8'hFF && es == 8'hFF && big[31] != sml[31]);
		inf_s2 <= eb == 8'hFF;
	end

	// add or subtract, count leading zeros
	logic [27:0] r3;
	logic [4:0]  lz3;

	logic [27:0] r_s3;
	logic [4:0]  lz_s3;
	logic [7:0]  e_s3;
	logic        sign_s3, nan_s3, inf_s3, zero_s3;

	always_comb begin
		if (sub_s2) begin
			r3 = {1'b0, ma_s2} - {1'b0, mb_s2};
		end else begin
			r3 = {1'b0, ma_s2} + {1'b0, mb_s2};
		end
		lz3 = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (r3[i]) begin
				lz3 = 5'(26 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		r_s3 <= r3;
		lz_s3 <= lz3;
		e_s3 <= e_s2;
		zero_s3 <= r3 == 28'd0;
		// exact cancellation rounds to +0
		sign_s3 <= (r3 == 28'd0 && sub_s2) ? 1'b0 : sign_s2;
		nan_s3 <= nan_s2;
		inf_s3 <= inf_s2;
	end

	// normalize and round to nearest even
	logic [7:0]  lim4, sh4;
	logic [26:0] n4;
	logic [23:0] m4;
	logic        g4, st4, up4;
	logic [8:0]  ee4;
	logic [24:0] mr4;
	logic [31:0] bits4, mag4;
	logic [31:0] sum_s4;

	always_comb begin
		lim4 = e_s3 - 8'd1;
		sh4 = ({3'b000, lz_s3} <= lim4) ? {3'b000, lz_s3} : lim4;
		n4 = r_s3[26:0] << sh4;
		if (r_s3[27]) begin
			m4 = r_s3[27:4];
			g4 = r_s3[3];
			st4 = |r_s3[2:0];
			ee4 = {1'b0, e_s3} + 9'd1;
		end else begin
			m4 = n4[26:3];
			g4 = n4[2];
			st4 = |n4[1:0];
			ee4 = {1'b0, e_s3} - {1'b0, sh4};
		end
		up4 = g4 & (st4 | m4[0]);
		mr4 = {1'b0, m4} + 25'(up4);
		bits4 = (32'(ee4 - 9'd1) << 23) + 32'(mr4);
		if (nan_s3) begin
			mag4 = FP_QNAN;
		end else if (inf_s3 || bits4 >= FP_INF) begin
			mag4 = FP_INF;
		end else if (zero_s3) begin
			mag4 = 32'd0;
		end else begin
			mag4 = bits4;
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= {sign_s3, mag4[30:0]};
	end

	assign sum = sum_s4;

endmodule

// File: src/sfpc_enc.sv
`timescale 1ns / 1ps

module sfpc_enc import sfpc_pkg::*; (
	input  logic        clk,
	input  enc_t        enc,
	input  logic [31:0] x,
	output logic [31:0] word
);

	// scale by the full-scale factor
	logic [30:0] k6;
	logic [23:0] m6;
	logic [54:0] p6;

	logic [54:0] p_s6;
	logic [7:0]  e_s6;
	logic        sign_s6, zero_s6;
	logic [31:0] x_s6;

	always_comb begin
		unique case (enc)
			ENC_PCM16: k6 = K_PCM16;
			ENC_PCM24: k6 = K_PCM24;
			default:   k6 = K_PCM32;
		endcase
		m6 = {1'b1, x[22:0]};
		p6 = 55'(m6) * 55'(k6);
	end

	always_ff @(posedge clk) begin
		p_s6 <= p6;
		e_s6 <= x[30:23];
		sign_s6 <= x[31];
		zero_s6 <= x[30:23] == 8'd0;
		x_s6 <= x;
	end

	// round the product to the working precision (24 or 53 bits)
	logic        t7, up7;
	logic [4:0]  d7;
	logic [55:0] pw7, keep7, low7, half7, v7;

	logic [55:0] v_s7;
	logic [7:0]  e_s7;
	logic        sign_s7, zero_s7;
	logic [31:0] x_s7;

	always_comb begin
		unique case (enc)
			ENC_PCM16: begin
				t7 = p_s6[38];
				d7 = 5'd14 + 5'(t7);
			end
			ENC_PCM24: begin
				t7 = p_s6[46];
				d7 = 5'd22 + 5'(t7);
			end
			default: begin
				t7 = p_s6[54];
				d7 = 5'd1 + 5'(t7);
			end
		endcase
		pw7 = {1'b0, p_s6};
		keep7 = pw7 >> d7;
		low7 = pw7 & ((56'd1 << d7) - 56'd1);
		half7 = 56'd1 << (d7 - 5'd1);
		up7 = (low7 > half7) || (low7 == half7 && keep7[0]);
		v7 = (keep7 + 56'(up7)) << d7;
	end

	always_ff @(posedge clk) begin
		v_s7 <= v7;
		e_s7 <= e_s6;
		sign_s7 <= sign_s6;
		zero_s7 <= zero_s6;
		x_s7 <= x_s6;
	end

	// drop the fraction, keep the half bit and sticky
	logic [7:0]  sh8;
	logic [5:0]  shm8;
	logic [32:0] int8;
	logic        half8, st8;

	logic [32:0] int_s8;
	logic        half_s8, st_s8, sign_s8, zero_s8;
	logic [31:0] x_s8;

	always_comb begin
		sh8 = 8'd150 - e_s7;
		shm8 = 6'(sh8 - 8'd1);
		if (sh8 >= 8'd57) begin
			int8 = 33'd0;
			half8 = 1'b0;
			st8 = 1'b0;
		end else begin
			int8 = 33'(v_s7 >> sh8);
			half8 = v_s7[shm8];
			st8 = |(v_s7 & ((56'd1 << shm8) - 56'd1));
		end
	end

	always_ff @(posedge clk) begin
		int_s8 <= int8;
		half_s8 <= half8;
		st_s8 <= st8;
		sign_s8 <= sign_s7;
		zero_s8 <= zero_s7;
		x_s8 <= x_s7;
	end

	// integer rounding, sign, packing
	logic        up9;
	logic [32:0] mag9, val9;
	logic [31:0] w9;
	logic [31:0] word_s9;

	always_comb begin
		if (enc == ENC_PCM32) begin
			up9 = half_s8;
		end else begin
			up9 = half_s8 & (st_s8 | int_s8[0]);
		end
		mag9 = int_s8 + 33'(up9);
		val9 = sign_s8 ? (33'd0 - mag9) : mag9;
		unique case (enc)
			ENC_FLOAT32: w9 = x_s8;
			ENC_PCM16:   w9 = zero_s8 ? 32'd0 : {16'd0, val9[15:0]};
			ENC_PCM24:   w9 = zero_s8 ? 32'd0 : {8'd0, val9[23:0]};
			default:     w9 = zero_s8 ? 32'd0 : val9[31:0];
		endcase
	end

	always_ff @(posedge clk) begin
		word_s9 <= w9;
	end

	assign word = word_s9;

endmodule

// File: src/stereo_float_to_pcm_converter.sv
`timescale 1ns / 1ps

// Channel   Signals                                   Transfer when
// --------  ----------------------------------------  ---------------------------
// frame in  start, busy, left_sample, right_sample    start && !busy
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
// words out result_valid, sample_word, byte_count,    every cycle result_valid
//           channel_index, last_of_frame              is high
//
// A frame crosses nine pipeline stages (float add, halve/clamp, scale, round,
// shift, integer round) and lands in a 16-frame buffer; a new frame can enter
// every cycle while busy is low. The word sequencer sends one word per cycle,
// as many words per frame as the channel count capped at eight; a frame with a
// channel count of zero is dropped without words.
// busy rises when 16 frames are in flight or buffered. Reset restores pcm16 and
// two channels and empties the pipeline; the receiver cannot stall, so each word
// shows for exactly one cycle.

module stereo_float_to_pcm_converter import sfpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] left_sample,
	input  logic [31:0] right_sample,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	output logic        result_valid,
	output logic [31:0] sample_word,
	output logic [2:0]  byte_count,
	output logic [2:0]  channel_index,
	output logic        last_of_frame
);

	// NaN to +0, then clamp to [-1, 1]
	function automatic logic [31:0] clamp_unit(input logic [31:0] v);
		logic [31:0] r;
		if (v[30:0] > FP_INF[30:0]) begin
			r = 32'd0;
		end else if (v[30:0] > FP_ONE[30:0]) begin
			r = {v[31], FP_ONE[30:0]};
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Multiply by 0.5 with round to nearest even where the result goes subnormal
	function automatic logic [31:0] halve(input logic [31:0] v);
		logic [31:0] r;
		logic [23:0] m;
		m = v[23:0];
		if (v[30:23] == 8'hFF) begin
			r = v;
		end else if (v[30:23] >= 8'd2) begin
			r = {v[31], v[30:23] - 8'd1, v[22:0]};
		end else begin
			r = {v[31], 7'd0, 24'((m >> 1) + 24'(m[0] & m[1]))};
		end
		return r;
	endfunction

	logic accept;
	assign accept = start && !busy;

	// configuration registers; writes are always taken
	enc_t       enc_q;
	logic [3:0] chans_q;
	logic [3:0] n_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q <= ENC_PCM16;
			chans_q <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SAMPLE_ENCODING) begin
				enc_q <= enc_t'(cfg_data[1:0]);
			end else if (cfg_index == REG_CHANNEL_COUNT) begin
				chans_q <= cfg_data;
			end
		end
	end

	// saturate to the channel limit
	assign n_eff = (chans_q > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chans_q;

	// valid bits, one per stage; the pipeline never holds
	logic [9:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[8:1], accept};
		end
	end

	// stage 1: capture the frame
	logic [31:0] left_s1, right_s1;
	logic [31:0] left_s2, right_s2, left_s3, right_s3, left_s4, right_s4;
	logic [31:0] sum_s4;

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1 <= left_sample;
			right_s1 <= right_sample;
		end
		left_s2 <= left_s1;
		right_s2 <= right_s1;
		left_s3 <= left_s2;
		right_s3 <= right_s2;
		left_s4 <= left_s3;
		right_s4 <= right_s3;
	end

	// stages 2..4: left + right in single precision
	sfpc_fadd u_fadd (
		.clk (clk),
		.a   (left_s1),
		.b   (right_s1),
		.sum (sum_s4)
	);

	// stage 5: pick mono downmix or left for lane a, clamp both lanes
	logic [31:0] a_s5, b_s5;

	always_ff @(posedge clk) begin
		a_s5 <= clamp_unit((n_eff == 4'd1) ? halve(sum_s4) : left_s4);
		b_s5 <= clamp_unit(right_s4);
	end

	// stages 6..9: encode both lanes
	logic [31:0] wa_s9, wb_s9;

	sfpc_enc u_enc_a (
		.clk  (clk),
		.enc  (enc_q),
		.x    (a_s5),
		.word (wa_s9)
	);

	sfpc_enc u_enc_b (
		.clk  (clk),
		.enc  (enc_q),
		.x    (b_s5),
		.word (wb_s9)
	);

	// frame buffer and credit count
	logic [31:0]        fa_q [FIFO_DEPTH];
	logic [31:0]        fb_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   fill_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [CH_W-1:0]    ch_q;
	logic               pop, emit, last;
	logic [31:0]        word_sel;

	assign busy = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (vld_q[9]) begin
			fa_q[wr_q] <= wa_s9;
			fb_q[wr_q] <= wb_s9;
		end
	end

	// sequencer: one word per cycle from the head frame, drop it after its last word
	always_comb begin
		last = (4'(ch_q) + 4'd1) == n_eff;
		emit = (fill_q != '0) && (n_eff != 4'd0);
		pop = (fill_q != '0) && ((n_eff == 4'd0) || last);
		if (ch_q == CH_W'(0)) begin
			word_sel = fa_q[rd_q];
		end else if (ch_q == CH_W'(1)) begin
			word_sel = fb_q[rd_q];
		end else begin
			word_sel = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			ch_q <= '0;
		end else begin
			if (vld_q[9]) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			fill_q <= fill_q + (FIFO_AW + 1)'(vld_q[9]) - (FIFO_AW + 1)'(pop);
			cnt_q <= cnt_q + (FIFO_AW + 1)'(accept) - (FIFO_AW + 1)'(pop);
			if (pop) begin
				ch_q <= '0;
			end else if (emit) begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
	end

	// result register: each word holds for one cycle
	logic        result_valid_q;
	logic [31:0] sample_word_q;
	logic [2:0]  byte_count_q;
	logic [2:0]  channel_index_q;
	logic        last_of_frame_q;
	logic [2:0]  bytes;

	always_comb begin
		unique case (enc_q)
			ENC_PCM16: bytes = 3'd2;
			ENC_PCM24: bytes = 3'd3;
			default:   bytes = 3'd4;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sample_word_q <= word_sel;
			byte_count_q <= bytes;
			channel_index_q <= 3'(ch_q);
			last_of_frame_q <= last;
		end
	end

	assign result_valid = result_valid_q;
	assign sample_word = sample_word_q;
	assign byte_count = byte_count_q;
	assign channel_index = channel_index_q;
	assign last_of_frame = last_of_frame_q;

`ifndef ASSERT_OFF
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("frame credit count overran the buffer depth");

	a_fill_le_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_q)
		else $error("buffer holds more frames than were accepted");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[9] |-> (fill_q < (FIFO_AW + 1)'(FIFO_DEPTH)) || pop)
		else $error("frame written into a full buffer");

	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && channel_index != 3'd0) |-> $past(result_valid))
		else $error("gap inside a frame's words");
`endif

endmodule

// File: tb/stereo_float_to_pcm_converter_tb.sv
`timescale 1ns / 1ps

class pcm_word_scoreboard;
	typedef struct {
		logic [31:0] word;
		logic [2:0]  bytes;
		logic [2:0]  chan;
		logic        last;
	} pcm_word_t;

	pcm_word_t   word_q[$];
	sfpc_pkg::enc_t encoding;
	logic [3:0]  chan_count;
	int          errors;
	int          frames;
	int          words;

	function new();
		encoding   = sfpc_pkg::ENC_PCM16;
		chan_count = 4'd2;
	endfunction

	function void write_reg(logic [1:0] idx, logic [3:0] data);
		if (idx == sfpc_pkg::REG_SAMPLE_ENCODING) begin
			encoding = sfpc_pkg::enc_t'(data[1:0]);
		end else if (idx == sfpc_pkg::REG_CHANNEL_COUNT) begin
			chan_count = data;
		end
	endfunction

	static function real f32_to_real(logic [31:0] b);
		logic [23:0] m;
		int          ex;
		logic [10:0] de;
		m = {1'b0, b[22:0]};
		if (b[30:23] == 8'hff)
			return $bitstoreal({b[31], 11'h7ff, (m != 0) ? 52'h8_0000_0000_0000 : 52'h0});
		if (b[30:23] == 8'h00) begin
			if (m == 0)
				return $bitstoreal({b[31], 63'h0});
			ex = -126;
			while (!m[23]) begin
				m = m << 1;
				ex--;
			end
		end else begin
			m[23] = 1'b1;
			ex = int'(b[30:23]) - 127;
		end
		de = 11'(ex + 1023);
		return $bitstoreal({b[31], de, m[22:0], 29'h0});
	endfunction

	// Round a double to the nearest single, ties to even, subnormals kept
	static function logic [31:0] real_to_f32(real x);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		int          ex;
		int          sh;
		d = $realtobits(x);
		if (d[62:52] == 11'h7ff)
			return (d[51:0] != 0) ? sfpc_pkg::FP_QNAN : {d[63], 31'h7f80_0000};
		if (d[62:52] == 11'h000)
			return {d[63], 31'h0};
		ex  = int'(d[62:52]) - 1023;
		sig = {11'h0, 1'b1, d[51:0]};
		sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
		if (sh > 60)
			return {d[63], 31'h0};
		q    = sig >> sh;
		rem  = sig & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		if (ex < -126)
			return {d[63], q[30:0]};
		if (q == (64'd1 << 24)) begin
			q = q >> 1;
			ex++;
		end
		if (ex > 127)
			return {d[63], 31'h7f80_0000};
		return {d[63], 8'(ex + 127), q[22:0]};
	endfunction

	static function logic [31:0] clamp_unit(logic [31:0] b);
		real v;
		if (b[30:23] == 8'hff && b[22:0] != 0)
			return 32'h0;
		v = f32_to_real(b);
		if (v < -1.0)
			return 32'hbf80_0000;
		if (v > 1.0)
			return sfpc_pkg::FP_ONE;
		return b;
	endfunction

	// Scale in single precision, then round half to even
	static function int scale_even(logic [31:0] b, real k);
		real p;
		real frac;
		int  t;
		p    = f32_to_real(real_to_f32(f32_to_real(b) * k));
		t    = $rtoi(p);
		frac = p - t;
		if (frac > 0.5 || (frac == 0.5 && t[0]))
			t++;
		else if (frac < -0.5 || (frac == -0.5 && t[0]))
			t--;
		return t;
	endfunction

	function void note_frame(logic [31:0] l, logic [31:0] r);
		logic [31:0] mono;
		logic [31:0] pick;
		logic [31:0] s;
		real         p;
		real         frac;
		longint      t;
		int          n;
		pcm_word_t   w;
		frames++;
		mono = real_to_f32(f32_to_real(real_to_f32(f32_to_real(l) + f32_to_real(r))) * 0.5);
		n = (chan_count > sfpc_pkg::MAX_CHANNELS) ? sfpc_pkg::MAX_CHANNELS : chan_count;
		for (int ch = 0; ch < n; ch++) begin
			if (n == 1)
				pick = mono;
			else if (ch == 0)
				pick = l;
			else if (ch == 1)
				pick = r;
			else
				pick = 32'h0;
			s = clamp_unit(pick);
			case (encoding)
				sfpc_pkg::ENC_FLOAT32: begin
					w.word  = s;
					w.bytes = 3'd4;
				end
				sfpc_pkg::ENC_PCM16: begin
					w.word  = 32'(scale_even(s, 32767.0)) & 32'h0000_ffff;
					w.bytes = 3'd2;
				end
				sfpc_pkg::ENC_PCM24: begin
					w.word  = 32'(scale_even(s, 8388607.0)) & 32'h00ff_ffff;
					w.bytes = 3'd3;
				end
				default: begin
					p    = f32_to_real(s) * 2147483647.0;
					t    = $rtoi(p);
					frac = p - t;
					if (frac >= 0.5)
						t++;
					else if (frac <= -0.5)
						t--;
					w.word  = t[31:0];
					w.bytes = 3'd4;
				end
			endcase
			w.chan = 3'(ch);
			w.last = (ch + 1 == n);
			word_q.push_back(w);
		end
	endfunction

	function void check_word(logic [31:0] word, logic [2:0] bytes, logic [2:0] chan,
			logic last);
		pcm_word_t w;
		words++;
		if (word_q.size() == 0) begin
			$error("unexpected word %h on channel %0d", word, chan);
			errors++;
			return;
		end
		w = word_q.pop_front();
		if (word !== w.word) begin
			$error("sample_word: expected %h, got %h", w.word, word);
			errors++;
		end
		if (bytes !== w.bytes) begin
			$error("byte_count: expected %0d, got %0d", w.bytes, bytes);
			errors++;
		end
		if (chan !== w.chan) begin
			$error("channel_index: expected %0d, got %0d", w.chan, chan);
			errors++;
		end
		if (last !== w.last) begin
			$error("last_of_frame: expected %0b, got %0b", w.last, last);
			errors++;
		end
	endfunction
endclass

module stereo_float_to_pcm_converter_tb;
	import sfpc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] left_sample;
	logic [31:0] right_sample;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        result_valid;
	logic [31:0] sample_word;
	logic [2:0]  byte_count;
	logic [2:0]  channel_index;
	logic        last_of_frame;

	pcm_word_scoreboard sb;
	int frames_taken;
	int cfg_taken;

	stereo_float_to_pcm_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.sample_word  (sample_word),
		.byte_count   (byte_count),
		.channel_index(channel_index),
		.last_of_frame(last_of_frame)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Observe every transfer at the rising edge; the scoreboard sees them in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
				cfg_taken++;
			end
			if (start && !busy) begin
				sb.note_frame(left_sample, right_sample);
				frames_taken++;
			end
			if (result_valid)
				sb.check_word(sample_word, byte_count, channel_index, last_of_frame);
		end
	end

	// Mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Hold the frame until it is taken, then optionally drop start for a gap
	task automatic send_frame(logic [31:0] l, logic [31:0] r, int gap);
		int n0;
		n0 = frames_taken;
		start        <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		do
			@(negedge clk);
		while (frames_taken == n0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drain all pending words, then let the pipeline settle before a register write
	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (sb.word_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [3:0] data);
		int n0;
		n0 = cfg_taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(negedge clk);
		while (cfg_taken == n0);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] special_value();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return FP_ONE;
			3: return 32'hbf80_0000;
			4: return FP_INF;
			5: return 32'hff80_0000;
			6: return FP_QNAN;
			7: return 32'hffff_ffff;
			8: return 32'h7f7f_ffff;
			9: return 32'h0000_0001;
			10: return 32'h3f80_0001;
			default: return 32'hbf7f_ffff;
		endcase
	endfunction

	// Weight toward the unit range where the rounding matters
	function automatic logic [31:0] rand_sample();
		real k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3:
				return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
			4: return {1'($urandom), 8'($urandom_range(127, 140)), 23'($urandom)};
			5: return {1'($urandom), 8'($urandom_range(0, 99)), 23'($urandom)};
			6: return special_value();
			7: begin
				// land near a rounding tie of pcm16 or pcm24
				k = ($urandom_range(0, 1) != 0) ? 32767.0 : 8388607.0;
				return sb.real_to_f32(
					($urandom_range(0, 32766) + 0.5) / k * (($urandom_range(0, 1) != 0) ? 1.0 : -1.0));
			end
			default: return $urandom;
		endcase
	endfunction

	typedef struct {
		enc_t       enc;
		logic [3:0] chans;
		int         count;
	} phase_t;

	phase_t phases[12];

	initial begin
		logic [31:0] dir_l[20];
		logic [31:0] dir_r[20];
		start        = 1'b0;
		left_sample  = 32'h0;
		right_sample = 32'h0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_SAMPLE_ENCODING;
		cfg_data     = 4'h0;
		frames_taken = 0;
		cfg_taken    = 0;
		sb = new();
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames at reset settings: zeros, full scale, infinities, NaN, overflow
		dir_l = '{32'h0000_0000, 32'h8000_0000, FP_ONE, 32'hbf80_0000, FP_INF,
			32'hff80_0000, FP_QNAN, 32'hffff_ffff, 32'h7f80_0001, 32'h3fc0_0000,
			32'hc000_0000, 32'h0000_0001, 32'h8000_0001, 32'h3f00_0000, 32'h7f7f_ffff,
			FP_INF, 32'h3f7f_ffff, 32'h3e80_0000, 32'h3a00_0000, 32'h7fff_ffff};
		dir_r = '{32'h8000_0000, 32'h8000_0000, 32'hbf80_0000, FP_ONE, 32'hff80_0000,
			32'h0000_0000, FP_ONE, 32'h3f00_0000, 32'h0000_0000, 32'hbfc0_0000,
			32'h4000_0000, 32'h0000_0001, 32'h8000_0001, 32'h3f00_0000, 32'h7f7f_ffff,
			32'hff80_0000, 32'h3f7f_ffff, 32'hbe80_0000, 32'hba00_0000, 32'h3f80_0000};
		for (int i = 0; i < 20; i++)
			send_frame(dir_l[i], dir_r[i], (i % 4 == 3) ? $urandom_range(1, 6) : 0);

		// Settings walk: every encoding, mono, stereo, wide, saturated and empty frames
		phases = '{
			'{ENC_FLOAT32, 4'd2, 45}, '{ENC_PCM32, 4'd8, 30}, '{ENC_PCM24, 4'd1, 45},
			'{ENC_PCM16, 4'd15, 25}, '{ENC_FLOAT32, 4'd1, 45}, '{ENC_PCM32, 4'd1, 45},
			'{ENC_PCM24, 4'd3, 40}, '{ENC_PCM16, 4'd0, 10}, '{ENC_PCM32, 4'd2, 45},
			'{ENC_FLOAT32, 4'd8, 30}, '{ENC_PCM16, 4'd1, 45}, '{ENC_PCM24, 4'd2, 40}};
		foreach (phases[p]) begin
			wait_idle();
			write_cfg(REG_SAMPLE_ENCODING, {2'($urandom), phases[p].enc});
			write_cfg(REG_CHANNEL_COUNT, phases[p].chans);
			// writes to unused indexes must change nothing
			if (p % 4 == 1)
				write_cfg(2'd2 + 2'($urandom_range(0, 1)), 4'($urandom));
			for (int i = 0; i < phases[p].count; i++)
				send_frame(rand_sample(), rand_sample(), pick_gap());
		end

		wait_idle();
		$display("Ran %0d frames through %0d encoding/channel settings, checked %0d words.",
			sb.frames, $size(phases) + 1, sb.words);
		if (sb.errors == 0 && sb.word_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// File: sim.f
src/sfpc_pkg.sv
src/sfpc_fadd.sv
src/sfpc_enc.sv
src/stereo_float_to_pcm_converter.sv
tb/stereo_float_to_pcm_converter_tb.sv
